FILE: rtl/bsc_pkg.sv
// Shared types and constants of the banker's safety check block.
// Payload structs, operation and result kind codes, register indexes, sequencer states.
// Depends on nothing.
package bsc_pkg;

  localparam int VALUE_W = 16;
  localparam int AVAIL_W = 24;
  localparam logic [AVAIL_W-1:0] AVAIL_TOP = {AVAIL_W{1'b1}};

  // Input operation codes
  localparam logic [1:0] OP_LOAD_ALLOC = 2'd0;
  localparam logic [1:0] OP_LOAD_MAX   = 2'd1;
  localparam logic [1:0] OP_LOAD_AVAIL = 2'd2;
  localparam logic [1:0] OP_RUN        = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_AVAIL  = 2'd0;
  localparam logic [1:0] KIND_SEQ    = 2'd1;
  localparam logic [1:0] KIND_UNSAFE = 2'd2;

  // Register indexes (bit 2 of the byte address)
  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT  = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         proc_index;
    logic [2:0]         res_index;
    logic [VALUE_W-1:0] value;
  } bsc_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         index;
    logic [AVAIL_W-1:0] amount;
    logic               last;
  } bsc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIT_READ,
    ST_FIT_CHECK,
    ST_GRANT_READ,
    ST_GRANT_ADD,
    ST_EMIT_AVAIL,
    ST_EMIT_SEQ
  } bsc_state_e;

endpackage

FILE: rtl/bsc_ram.sv
// Generic single write port, single read port memory with registered read data.
// Holds the allocation and maximum tables. Depends on nothing.
module bsc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bsc_alu.sv
// Shared arithmetic unit: clipped need against available, and saturating add-back.
// Depends on bsc_pkg for the field widths.
module bsc_alu (
  input  logic [bsc_pkg::AVAIL_W-1:0] avail_i,
  input  logic [bsc_pkg::VALUE_W-1:0] alloc_i,
  input  logic [bsc_pkg::VALUE_W-1:0] max_i,
  output logic                        no_fit_o,
  output logic [bsc_pkg::AVAIL_W-1:0] sum_o
);
  import bsc_pkg::*;

  logic [VALUE_W-1:0] need;
  logic [AVAIL_W:0]   sum_wide;

  // Negative need counts as zero
  assign need     = (max_i > alloc_i) ? (max_i - alloc_i) : '0;
  assign no_fit_o = AVAIL_W'(need) > avail_i;

  assign sum_wide = {1'b0, avail_i} + (AVAIL_W + 1)'(alloc_i);
  assign sum_o    = sum_wide[AVAIL_W] ? AVAIL_TOP : sum_wide[AVAIL_W-1:0];

endmodule

FILE: rtl/bankers_safety_check.sv
// Top level of the banker's safety check: APB registers, sequencer, tables, result beats.
// Depends on bsc_pkg, bsc_ram and bsc_alu.
//
// Load items (allocation, maximum, available) leave busy low, so loads can arrive back to
// back. A run item raises busy and walks the processes in index order, sweep after sweep,
// through one shared compare/add unit fed by the registered read port of the two table
// memories. Per sweep a process that is already finished is only passed over in the scan
// state; any other process is checked resource by resource, a read state then a check
// state each, and the check stops at the first resource that does not fit. When all fit,
// the process is granted: each resource passes a read state and an add state in turn.
// Each sweep ends in the scan state with a choice between another sweep, the result beats
// and the unsafe verdict. A safe run then streams nr available
// beats followed by np safe sequence beats, one beat per cycle with last on the final one;
// an unsafe run gives a single unsafe beat with last set. Each beat shows on res_o for
// exactly one cycle with res_valid_o high; the receiver cannot stall, so capture every
// beat. busy drops with the final beat, and the next item can be accepted in that cycle.
// Write proc_count and res_count only while busy is low.
module bankers_safety_check #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_RES   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  bsc_pkg::bsc_in_t  item_i,
  // result channel
  output logic              res_valid_o,
  output bsc_pkg::bsc_out_t res_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bsc_pkg::*;

  localparam int PW    = $clog2(MAX_PROCS + 1);            // counts 0..MAX_PROCS
  localparam int RCW   = $clog2(MAX_RES + 1);              // counts 0..MAX_RES
  localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int DEPTH = MAX_PROCS * MAX_RES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [4:0] proc_count_q;
  logic [3:0] res_count_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q <= 5'd16;
      res_count_q  <= 4'd8;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PROC_COUNT: proc_count_q <= pwdata[4:0];
        REG_RES_COUNT:  res_count_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PROC_COUNT: prdata = 32'(proc_count_q);
      REG_RES_COUNT:  prdata = 32'(res_count_q);
      default:        prdata = '0;
    endcase
  end

  // Clamp the counts into 1..MAX
  logic [PW-1:0]  np_cfg;
  logic [RCW-1:0] nr_cfg;

  always_comb begin
    if (proc_count_q == '0) begin
      np_cfg = PW'(1);
    end else if (int'(proc_count_q) > MAX_PROCS) begin
      np_cfg = PW'(MAX_PROCS);
    end else begin
      np_cfg = PW'(proc_count_q);
    end
    if (res_count_q == '0) begin
      nr_cfg = RCW'(1);
    end else if (int'(res_count_q) > MAX_RES) begin
      nr_cfg = RCW'(MAX_RES);
    end else begin
      nr_cfg = RCW'(res_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  bsc_state_e          state_q, state_d;
  logic [PW-1:0]       np_q, np_d;
  logic [RCW-1:0]      nr_q, nr_d;
  logic [PW-1:0]       p_q, p_d;
  logic [RCW-1:0]      r_q, r_d;
  logic [PW-1:0]       gcnt_q, gcnt_d;
  logic [MAX_PROCS-1:0] mask_q, mask_d;
  logic                prog_q, prog_d;
  logic                res_valid_q, res_valid_d;
  bsc_out_t            res_q, res_d;

  logic [PIW-1:0]      p_idx;
  logic [RIW-1:0]      r_idx;
  logic [PIW-1:0]      gcnt_idx;

  assign p_idx    = p_q[PIW-1:0];
  assign r_idx    = r_q[RIW-1:0];
  assign gcnt_idx = gcnt_q[PIW-1:0];

  // ---------------------------------------------------------------------------
  // Storage: available vector and safe order in flops, tables in memories
  // ---------------------------------------------------------------------------
  logic [AVAIL_W-1:0] avail_q [MAX_RES];
  logic [3:0]         safe_q  [MAX_PROCS];

  logic               accept;
  logic               load_tbl_ok;
  logic [AW-1:0]      load_addr;
  logic [AW-1:0]      tbl_raddr;
  logic [VALUE_W-1:0] alloc_rd;
  logic [VALUE_W-1:0] max_rd;
  logic [RIW-1:0]     load_ridx;

  logic               avail_we;
  logic [RIW-1:0]     avail_widx;
  logic [AVAIL_W-1:0] avail_wdata;
  logic               safe_we;

  logic               no_fit;
  logic [AVAIL_W-1:0] sum_sat;

  assign accept      = start && !busy;
  assign load_tbl_ok = (int'(item_i.proc_index) < MAX_PROCS) &&
                       (int'(item_i.res_index) < MAX_RES);
  assign load_addr   = AW'(int'(item_i.proc_index) * MAX_RES + int'(item_i.res_index));
  assign load_ridx   = RIW'(item_i.res_index);
  assign tbl_raddr   = AW'(int'(p_idx) * MAX_RES + int'(r_idx));

  bsc_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_W)
  ) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (item_i.op == OP_LOAD_ALLOC) && load_tbl_ok),
    .waddr_i (load_addr),
    .wdata_i (item_i.value),
    .raddr_i (tbl_raddr),
    .rdata_o (alloc_rd)
  );

  bsc_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_W)
  ) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (item_i.op == OP_LOAD_MAX) && load_tbl_ok),
    .waddr_i (load_addr),
    .wdata_i (item_i.value),
    .raddr_i (tbl_raddr),
    .rdata_o (max_rd)
  );

  bsc_alu u_alu (
    .avail_i  (avail_q[r_idx]),
    .alloc_i  (alloc_rd),
    .max_i    (max_rd),
    .no_fit_o (no_fit),
    .sum_o    (sum_sat)
  );

  always_ff @(posedge clk_i) begin
    if (avail_we) begin
      avail_q[avail_widx] <= avail_wdata;
    end
    if (safe_we) begin
      safe_q[gcnt_idx] <= 4'(p_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    np_d        = np_q;
    nr_d        = nr_q;
    p_d         = p_q;
    r_d         = r_q;
    gcnt_d      = gcnt_q;
    mask_d      = mask_q;
    prog_d      = prog_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    avail_we    = 1'b0;
    avail_widx  = r_idx;
    avail_wdata = sum_sat;
    safe_we     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.op == OP_RUN) begin
            // latch counts, clear the run state, start the first sweep
            np_d    = np_cfg;
            nr_d    = nr_cfg;
            p_d     = '0;
            gcnt_d  = '0;
            mask_d  = '0;
            prog_d  = 1'b0;
            state_d = ST_SCAN;
          end else if (item_i.op == OP_LOAD_AVAIL) begin
            if (int'(item_i.res_index) < MAX_RES) begin
              avail_we    = 1'b1;
              avail_widx  = load_ridx;
              avail_wdata = AVAIL_W'(item_i.value);
            end
          end
        end
      end

      ST_SCAN: begin
        if (p_q == np_q) begin
          // end of a sweep
          if (gcnt_q == np_q) begin
            r_d     = '0;
            state_d = ST_EMIT_AVAIL;
          end else if (!prog_q) begin
            res_valid_d  = 1'b1;
            res_d.kind   = KIND_UNSAFE;
            res_d.index  = '0;
            res_d.amount = '0;
            res_d.last   = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            p_d    = '0;
            prog_d = 1'b0;
          end
        end else if (mask_q[p_idx]) begin
          p_d = p_q + PW'(1);
        end else begin
          r_d     = '0;
          state_d = ST_FIT_READ;
        end
      end

      ST_FIT_READ: begin
        state_d = ST_FIT_CHECK;
      end

      ST_FIT_CHECK: begin
        if (no_fit) begin
          p_d     = p_q + PW'(1);
          state_d = ST_SCAN;
        end else if (r_q == nr_q - RCW'(1)) begin
          r_d     = '0;
          state_d = ST_GRANT_READ;
        end else begin
          r_d     = r_q + RCW'(1);
          state_d = ST_FIT_READ;
        end
      end

      ST_GRANT_READ: begin
        state_d = ST_GRANT_ADD;
      end

      ST_GRANT_ADD: begin
        // add the allocation back, saturating
        avail_we = 1'b1;
        if (r_q == nr_q - RCW'(1)) begin
          mask_d  = mask_q | (MAX_PROCS'(1) << p_idx);
          safe_we = 1'b1;
          gcnt_d  = gcnt_q + PW'(1);
          prog_d  = 1'b1;
          p_d     = p_q + PW'(1);
          state_d = ST_SCAN;
        end else begin
          r_d     = r_q + RCW'(1);
          state_d = ST_GRANT_READ;
        end
      end

      ST_EMIT_AVAIL: begin
        res_valid_d  = 1'b1;
        res_d.kind   = KIND_AVAIL;
        res_d.index  = 4'(r_q);
        res_d.amount = avail_q[r_idx];
        res_d.last   = 1'b0;
        if (r_q == nr_q - RCW'(1)) begin
          p_d     = '0;
          state_d = ST_EMIT_SEQ;
        end else begin
          r_d = r_q + RCW'(1);
        end
      end

      ST_EMIT_SEQ: begin
        res_valid_d  = 1'b1;
        res_d.kind   = KIND_SEQ;
        res_d.index  = safe_q[p_idx];
        res_d.amount = '0;
        res_d.last   = (p_q == np_q - PW'(1));
        if (p_q == np_q - PW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          p_d = p_q + PW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      np_q        <= '0;
      nr_q        <= '0;
      p_q         <= '0;
      r_q         <= '0;
      gcnt_q      <= '0;
      mask_q      <= '0;
      prog_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      np_q        <= np_d;
      nr_q        <= nr_d;
      p_q         <= p_d;
      r_q         <= r_d;
      gcnt_q      <= gcnt_d;
      mask_q      <= mask_d;
      prog_q      <= prog_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload holds no control state
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/bsc_checker.sv
// Port-level checks on the banker's safety check top level, with the bind that attaches them.
// Depends on bsc_pkg and the bankers_safety_check ports.
module bsc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input bsc_pkg::bsc_in_t  item_i,
  input logic              res_valid_o,
  input bsc_pkg::bsc_out_t res_o
);
  import bsc_pkg::*;

  // A run raises busy on the next cycle
  a_run_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.op == OP_RUN)) |=> busy)
    else $error("run item did not raise busy");

  // Loads finish in the cycle they are taken
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.op != OP_RUN)) |=> !busy)
    else $error("load item raised busy");

  // Beats of a run are contiguous up to the last one
  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> res_valid_o)
    else $error("gap inside a result burst");

  // The last beat ends the burst
  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("beat right after the last beat");

  // An unsafe verdict is a single beat
  a_unsafe_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KIND_UNSAFE)) |-> (res_o.last && !busy))
    else $error("unsafe verdict not a lone final beat");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
